@@ src/line_follow_pid_steering_core_macros.svh @@
// ---------------------------------------------------------------------------
// Line-follow PID steering core: assertion macros
// Shared property shapes for the port-level checks.
// ---------------------------------------------------------------------------
`ifndef LINE_FOLLOW_PID_STEERING_CORE_MACROS_SVH
`define LINE_FOLLOW_PID_STEERING_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define LFPS_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("lfps port check failed");

// Next-cycle implication, disabled during reset
`define LFPS_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("lfps port check failed");

`endif

@@ src/lfps_pkg.sv @@
// ---------------------------------------------------------------------------
// lfps_pkg
// Types, constants and the microcode table of the line-follow PID core.
// ---------------------------------------------------------------------------
package lfps_pkg;

  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int GAIN_W  = 24;
  localparam int BASE_W  = 8;
  localparam int OFS_W   = 10;
  localparam int SCALE_W = 12;
  localparam int SAMP_W  = 10;
  localparam int DIFF_W  = 12;
  localparam int POS_W   = 16;
  localparam int DELTA_W = POS_W + 1;
  localparam int CORR_W  = 9;
  localparam int STEP_W  = 4;

  // Register reset values
  localparam logic [GAIN_W-1:0]  KP_RESET     = 24'd39322;
  localparam logic [GAIN_W-1:0]  KI_RESET     = 24'd26;
  localparam logic [GAIN_W-1:0]  KD_RESET     = 24'd98304;
  localparam logic [BASE_W-1:0]  BASE_RESET   = 8'd40;
  localparam logic [OFS_W-1:0]   OFFSET_RESET = 10'd60;
  localparam logic [SCALE_W-1:0] SCALE_RESET  = 12'd358;

  // Register map, word index
  typedef enum logic [2:0] {
    REG_KP     = 3'd0,
    REG_KI     = 3'd1,
    REG_KD     = 3'd2,
    REG_BASE   = 3'd3,
    REG_OFFSET = 3'd4,
    REG_SCALE  = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    MUL_SCALE = 2'd0,
    MUL_KP    = 2'd1,
    MUL_KI    = 2'd2,
    MUL_KD    = 2'd3
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_ADD  = 2'd2
  } acc_op_t;

  typedef enum logic [1:0] {
    HOLD_NONE = 2'd0,
    HOLD_IN   = 2'd1,
    HOLD_OUT  = 2'd2
  } hold_t;

  // One control word per program step
  typedef struct packed {
    logic              idle;
    mul_sel_t          mul_sel;
    logic              mul_en;
    acc_op_t           acc_op;
    logic              pos_en;
    logic              ring_en;
    logic              quot_en;
    logic              out_en;
    hold_t             hold;
    logic [STEP_W-1:0] next_step;
  } ctrl_t;

  // Program steps
  localparam logic [STEP_W-1:0] S_WAIT    = 4'd0;
  localparam logic [STEP_W-1:0] S_MUL_POS = 4'd1;
  localparam logic [STEP_W-1:0] S_POS     = 4'd2;
  localparam logic [STEP_W-1:0] S_MUL_KP  = 4'd3;
  localparam logic [STEP_W-1:0] S_MUL_KI  = 4'd4;
  localparam logic [STEP_W-1:0] S_MUL_KD  = 4'd5;
  localparam logic [STEP_W-1:0] S_ACC_KD  = 4'd6;
  localparam logic [STEP_W-1:0] S_QUOT    = 4'd7;
  localparam logic [STEP_W-1:0] S_OUT     = 4'd8;

  // Read-only microcode table
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t c;
    c           = '0;
    c.mul_sel   = MUL_SCALE;
    c.acc_op    = ACC_HOLD;
    c.hold      = HOLD_NONE;
    c.next_step = S_WAIT;
    case (step)
      S_WAIT: begin
        c.idle      = 1'b1;
        c.hold      = HOLD_IN;
        c.next_step = S_MUL_POS;
      end
      S_MUL_POS: begin
        c.mul_sel   = MUL_SCALE;
        c.mul_en    = 1'b1;
        c.next_step = S_POS;
      end
      S_POS: begin
        c.pos_en    = 1'b1;
        c.next_step = S_MUL_KP;
      end
      S_MUL_KP: begin
        c.mul_sel   = MUL_KP;
        c.mul_en    = 1'b1;
        c.ring_en   = 1'b1;
        c.next_step = S_MUL_KI;
      end
      S_MUL_KI: begin
        c.mul_sel   = MUL_KI;
        c.mul_en    = 1'b1;
        c.acc_op    = ACC_LOAD;
        c.next_step = S_MUL_KD;
      end
      S_MUL_KD: begin
        c.mul_sel   = MUL_KD;
        c.mul_en    = 1'b1;
        c.acc_op    = ACC_ADD;
        c.next_step = S_ACC_KD;
      end
      S_ACC_KD: begin
        c.acc_op    = ACC_ADD;
        c.next_step = S_QUOT;
      end
      S_QUOT: begin
        c.quot_en   = 1'b1;
        c.next_step = S_OUT;
      end
      S_OUT: begin
        c.out_en    = 1'b1;
        c.hold      = HOLD_OUT;
        c.next_step = S_WAIT;
      end
      default: begin
        c.next_step = S_WAIT;
      end
    endcase
    return c;
  endfunction

endpackage

@@ src/line_follow_pid_steering_core.sv @@
// ---------------------------------------------------------------------------
// line_follow_pid_steering_core
// Line position from two reflectance samples, windowed-integral PID steering
// correction and the two motor speeds, run by a small microcoded sequencer
// around one shared multiplier.
//
//   channel  | handshake                      | payload
//   ---------+--------------------------------+----------------------------------
//   input    | in_valid / in_ready            | left_sample, right_sample
//   result   | out_valid / out_ready          | right_speed, left_speed,
//            |                                | steer_correction
//   config   | psel/penable/pwrite/pready     | paddr, pwdata, prdata
//
// An item runs through one accept step and eight program steps, set by the
// four products that go through the single multiplier in turn.
// The next request is taken only once the program is back at the accept step.
// A result not yet taken holds the last program step until out_ready.
// Reset clears the window ring through per-entry valid bits.
// ---------------------------------------------------------------------------
module line_follow_pid_steering_core
  import lfps_pkg::*;
#(
  parameter int WINDOW = 20
) (
  input  logic                     clk,
  input  logic                     rst,
  // input request
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [SAMP_W-1:0]        left_sample,
  input  logic [SAMP_W-1:0]        right_sample,
  // result request
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [BASE_W-1:0]        right_speed,
  output logic [BASE_W-1:0]        left_speed,
  output logic signed [CORR_W-1:0] steer_correction,
  // configuration
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready
);

  localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W = POS_W + $clog2(WINDOW);
  localparam int BW    = (SUM_W > DELTA_W) ? SUM_W : DELTA_W;
  localparam int PW    = GAIN_W + 1 + BW;
  localparam int AW    = PW + 2;
  localparam int QW    = AW - 16;

  // Configuration registers
  logic [GAIN_W-1:0]  kp_gain;
  logic [GAIN_W-1:0]  ki_gain;
  logic [GAIN_W-1:0]  kd_gain;
  logic [BASE_W-1:0]  base_speed;
  logic [OFS_W-1:0]   calib_offset;
  logic [SCALE_W-1:0] calib_scale;

  logic     cfg_wr;
  reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[4:2]);

  // Write configuration on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      kp_gain      <= KP_RESET;
      ki_gain      <= KI_RESET;
      kd_gain      <= KD_RESET;
      base_speed   <= BASE_RESET;
      calib_offset <= OFFSET_RESET;
      calib_scale  <= SCALE_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_KP:     kp_gain      <= pwdata[GAIN_W-1:0];
        REG_KI:     ki_gain      <= pwdata[GAIN_W-1:0];
        REG_KD:     kd_gain      <= pwdata[GAIN_W-1:0];
        REG_BASE:   base_speed   <= pwdata[BASE_W-1:0];
        REG_OFFSET: calib_offset <= pwdata[OFS_W-1:0];
        REG_SCALE:  calib_scale  <= pwdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (cfg_idx)
      REG_KP:     prdata = DATA_W'(kp_gain);
      REG_KI:     prdata = DATA_W'(ki_gain);
      REG_KD:     prdata = DATA_W'(kd_gain);
      REG_BASE:   prdata = DATA_W'(base_speed);
      REG_OFFSET: prdata = DATA_W'(calib_offset);
      REG_SCALE:  prdata = DATA_W'(calib_scale);
      default:    prdata = '0;
    endcase
  end

  // Sequencer: step counter, control word, holds
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  ctrl_t             ctrl;
  logic              in_fire;
  logic              hold_now;
  logic              out_load;

  assign ctrl     = ucode(step);
  assign in_ready = ctrl.idle;
  assign in_fire  = in_valid && in_ready;
  assign hold_now = ((ctrl.hold == HOLD_IN) && !in_fire) ||
                    ((ctrl.hold == HOLD_OUT) && out_valid && !out_ready);
  assign out_load = ctrl.out_en && !hold_now;
  assign step_next = hold_now ? step : ctrl.next_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_WAIT;
    end else begin
      step <= step_next;
    end
  end

  // Capture the offset sensor difference on accept
  logic signed [DIFF_W-1:0] diff;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      diff <= $signed({2'b00, left_sample}) - $signed({2'b00, right_sample})
            + DIFF_W'($signed(calib_offset));
    end
  end

  // Window ring memory with registered read
  logic signed [POS_W-1:0] ring [WINDOW];
  logic signed [POS_W-1:0] ring_rd;
  logic [WINDOW-1:0]       ring_vld;
  logic [PTR_W-1:0]        ptr;
  logic signed [POS_W-1:0] pos;
  logic signed [POS_W-1:0] old_pos;

  always_ff @(posedge clk) begin
    if (ctrl.ring_en) begin
      ring[ptr] <= pos;
    end
    ring_rd <= ring[ptr];
  end

  assign old_pos = ring_vld[ptr] ? ring_rd : '0;

  // Shared multiplier
  logic signed [GAIN_W:0]  mul_a;
  logic signed [BW-1:0]    mul_b;
  logic signed [PW-1:0]    prod;
  logic signed [SUM_W-1:0] sum;
  logic signed [DELTA_W-1:0] delta;

  always_comb begin
    case (ctrl.mul_sel)
      MUL_SCALE: begin
        mul_a = $signed({1'b0, GAIN_W'(calib_scale)});
        mul_b = BW'(diff);
      end
      MUL_KP: begin
        mul_a = $signed({1'b0, kp_gain});
        mul_b = BW'(pos);
      end
      MUL_KI: begin
        mul_a = $signed({1'b0, ki_gain});
        mul_b = BW'(sum);
      end
      MUL_KD: begin
        mul_a = $signed({1'b0, kd_gain});
        mul_b = BW'(delta);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= mul_a * mul_b;
    end
  end

  // Position: divide by 256, truncate toward zero
  logic signed [PW-1:0] pos_round;

  assign pos_round = prod + $signed({{(PW-8){1'b0}}, {8{prod[PW-1]}}});

  always_ff @(posedge clk) begin
    if (ctrl.pos_en) begin
      pos <= pos_round[8 +: POS_W];
    end
  end

  // Window state: sum, ring pointer, previous position, derivative term
  logic signed [POS_W-1:0] prev;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum      <= '0;
      prev     <= '0;
      ptr      <= '0;
      ring_vld <= '0;
    end else if (ctrl.ring_en) begin
      sum           <= sum - SUM_W'(old_pos) + SUM_W'(pos);
      prev          <= pos;
      ring_vld[ptr] <= 1'b1;
      ptr           <= (ptr == PTR_W'(WINDOW - 1)) ? '0 : ptr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ring_en) begin
      delta <= DELTA_W'(pos) - DELTA_W'(prev);
    end
  end

  // Accumulate the three products
  logic signed [AW-1:0] acc;

  always_ff @(posedge clk) begin
    case (ctrl.acc_op)
      ACC_LOAD: acc <= AW'(prod);
      ACC_ADD:  acc <= acc + AW'(prod);
      default:  ;
    endcase
  end

  // Correction: divide by 65536, truncate toward zero
  logic signed [AW-1:0] acc_round;
  logic signed [QW-1:0] quot;

  assign acc_round = acc + $signed({{(AW-16){1'b0}}, {16{acc[AW-1]}}});

  always_ff @(posedge clk) begin
    if (ctrl.quot_en) begin
      quot <= acc_round[AW-1:16];
    end
  end

  // Clamp to the base speed and split into motor speeds
  logic signed [QW-1:0]     base_ext;
  logic signed [CORR_W-1:0] corr;
  logic [BASE_W-1:0]        rs;
  logic [BASE_W-1:0]        ls;

  assign base_ext = $signed({{(QW-BASE_W){1'b0}}, base_speed});

  always_comb begin
    if (quot > base_ext) begin
      corr = $signed({1'b0, base_speed});
    end else if (quot < -base_ext) begin
      corr = -$signed({1'b0, base_speed});
    end else begin
      corr = quot[CORR_W-1:0];
    end
    rs = corr[CORR_W-1] ? base_speed : base_speed - corr[BASE_W-1:0];
    ls = (corr > 0) ? base_speed : base_speed + corr[BASE_W-1:0];
  end

  // Output register: load a new result, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      right_speed      <= rs;
      left_speed       <= ls;
      steer_correction <= corr;
    end
  end

endmodule

@@ src/lfps_checker.sv @@
// ---------------------------------------------------------------------------
// lfps_checker
// Port-level checks of the line-follow PID core, bound to the top level.
// ---------------------------------------------------------------------------
`include "line_follow_pid_steering_core_macros.svh"

module lfps_checker
  import lfps_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [BASE_W-1:0]        right_speed,
  input logic [BASE_W-1:0]        left_speed,
  input logic signed [CORR_W-1:0] steer_correction
);

  // Hold a stalled result and its payload
  `LFPS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(right_speed) && $stable(left_speed) && $stable(steer_correction))

  // Speeds differ by exactly the correction
  `LFPS_ASSERT_SAME(a_speed_split, clk, rst, out_valid, (10'(left_speed) - 10'(right_speed)) == 10'(steer_correction))

  // Correction never reaches the unused negative extreme
  `LFPS_ASSERT_SAME(a_corr_range, clk, rst, out_valid, steer_correction != -9'sd256)

  // Take one request at a time
  `LFPS_ASSERT_NEXT(a_one_in_flight, clk, rst, in_valid && in_ready, !in_ready)

endmodule

bind line_follow_pid_steering_core lfps_checker u_lfps_checker (.*);

@@ test/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top: line-follow PID steering core testbench
// Drives sample pairs through the request handshake and programs the gains
// over the register port. Every result is checked against a cycle-free
// software copy of the steering math: position scaling, the windowed sum,
// the PID terms, the clamp and the two motor speeds. A short table of
// directed requests runs first, then randomized phases with new settings.
// ---------------------------------------------------------------------------
module tb_top;
  import lfps_pkg::*;

  localparam int WIN         = 20;
  localparam int SUM_W       = 21;
  localparam int NUM_REGS    = REG_SCALE + 1;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 200;
  localparam int SETTLE      = 12;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PRINT_LIMIT = 40;

  // Register indexes past the end of the map
  localparam logic [2:0] IDX_SPARE_LO = 3'd6;
  localparam logic [2:0] IDX_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [BASE_W-1:0]        rs;
    logic [BASE_W-1:0]        ls;
    logic signed [CORR_W-1:0] corr;
  } steer_t;

  typedef struct {
    logic              is_cfg;
    logic [2:0]        idx;
    logic [DATA_W-1:0] value;
    logic [SAMP_W-1:0] l;
    logic [SAMP_W-1:0] r;
    logic              known;
    steer_t            want;
  } stim_row_t;

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  logic [SAMP_W-1:0]        left_sample;
  logic [SAMP_W-1:0]        right_sample;
  logic                     out_valid;
  logic                     out_ready;
  logic [BASE_W-1:0]        right_speed;
  logic [BASE_W-1:0]        left_speed;
  logic signed [CORR_W-1:0] steer_correction;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [ADDR_W-1:0]        paddr;
  logic [DATA_W-1:0]        pwdata;
  logic [DATA_W-1:0]        prdata;
  logic                     pready;

  // Shadow configuration and steering state
  logic [GAIN_W-1:0]         gain_kp;
  logic [GAIN_W-1:0]         gain_ki;
  logic [GAIN_W-1:0]         gain_kd;
  logic [BASE_W-1:0]         cruise;
  logic signed [OFS_W-1:0]   cal_offset;
  logic [SCALE_W-1:0]        cal_scale;
  logic signed [POS_W-1:0]   pos_hist [WIN];
  int unsigned               hist_ptr;
  logic signed [SUM_W-1:0]   hist_sum;
  logic signed [POS_W-1:0]   last_pos;

  steer_t      pending_steer_q [$];
  stim_row_t   dir_tab [$];
  int          mismatch_count;
  int          cycle_count;
  bit          in_gap_on;
  bit          out_stall_on;

  line_follow_pid_steering_core i_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .left_sample      (left_sample),
    .right_sample     (right_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .right_speed      (right_speed),
    .left_speed       (left_speed),
    .steer_correction (steer_correction),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_LIMIT) begin
      $display("MISMATCH @%0d: %s", cycle_count, msg);
    end
    mismatch_count++;
  endtask

  function automatic logic [DATA_W-1:0] reg_mask(input logic [2:0] idx);
    case (idx)
      REG_KP, REG_KI, REG_KD: return (DATA_W'(1) << GAIN_W) - 1;
      REG_BASE:               return (DATA_W'(1) << BASE_W) - 1;
      REG_OFFSET:             return (DATA_W'(1) << OFS_W) - 1;
      REG_SCALE:              return (DATA_W'(1) << SCALE_W) - 1;
      default:                return '0;
    endcase
  endfunction

  task automatic reset_steering();
    gain_kp    = KP_RESET;
    gain_ki    = KI_RESET;
    gain_kd    = KD_RESET;
    cruise     = BASE_RESET;
    cal_offset = OFFSET_RESET;
    cal_scale  = SCALE_RESET;
    foreach (pos_hist[k]) pos_hist[k] = '0;
    hist_ptr = 0;
    hist_sum = '0;
    last_pos = '0;
  endtask

  // Mirror a register write; indexes past the map are dropped
  task automatic apply_reg(input logic [2:0] idx, input logic [DATA_W-1:0] value);
    case (idx)
      REG_KP:     gain_kp    = value[GAIN_W-1:0];
      REG_KI:     gain_ki    = value[GAIN_W-1:0];
      REG_KD:     gain_kd    = value[GAIN_W-1:0];
      REG_BASE:   cruise     = value[BASE_W-1:0];
      REG_OFFSET: cal_offset = value[OFS_W-1:0];
      REG_SCALE:  cal_scale  = value[SCALE_W-1:0];
      default: ;
    endcase
  endtask

  // Position, windowed sum, PID terms, clamp and motor speeds for one pair
  task automatic compute_steering(input logic [SAMP_W-1:0] l, input logic [SAMP_W-1:0] r,
                                  output steer_t res);
    longint diff, p, acc, c, b, rs, ls;
    diff = longint'(l) - longint'(r) + longint'(cal_offset);
    p    = (diff * longint'(cal_scale)) / 256;
    hist_sum = SUM_W'(longint'(hist_sum) - longint'(pos_hist[hist_ptr]) + p);
    pos_hist[hist_ptr] = POS_W'(p);
    hist_ptr = (hist_ptr + 1) % WIN;
    acc = longint'(gain_kp) * p
        + longint'(gain_ki) * longint'(hist_sum)
        + longint'(gain_kd) * (p - longint'(last_pos));
    c = acc / 65536;
    last_pos = POS_W'(p);
    b = longint'(cruise);
    if (c > b) c = b;
    if (c < -b) c = -b;
    rs = (c < 0) ? b : b - c;
    ls = (c > 0) ? b : b + c;
    res.rs   = rs[BASE_W-1:0];
    res.ls   = ls[BASE_W-1:0];
    res.corr = c[CORR_W-1:0];
  endtask

  function automatic stim_row_t cfg_row(input logic [2:0] idx, input logic [DATA_W-1:0] value);
    stim_row_t row;
    row        = '{default: '0};
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.value  = value;
    return row;
  endfunction

  function automatic stim_row_t pair_row(input logic [SAMP_W-1:0] l, input logic [SAMP_W-1:0] r);
    stim_row_t row;
    row   = '{default: '0};
    row.l = l;
    row.r = r;
    return row;
  endfunction

  function automatic stim_row_t pair_known(input logic [SAMP_W-1:0] l,
                                           input logic [SAMP_W-1:0] r,
                                           input logic [BASE_W-1:0] rs,
                                           input logic [BASE_W-1:0] ls,
                                           input logic signed [CORR_W-1:0] corr);
    stim_row_t row;
    row       = pair_row(l, r);
    row.known = 1'b1;
    row.want  = '{rs: rs, ls: ls, corr: corr};
    return row;
  endfunction

  // Present one sample pair, hold it until accepted, then queue its result
  task automatic send_pair(input logic [SAMP_W-1:0] l, input logic [SAMP_W-1:0] r,
                           input logic known, input steer_t want);
    steer_t res;
    @(negedge clk);
    if (in_gap_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    left_sample  <= l;
    right_sample <= r;
    do @(posedge clk); while (!in_ready);
    compute_steering(l, r, res);
    pending_steer_q.push_back(known ? want : res);
  endtask

  // Drop valid and hold until every queued result is out
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_steer_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Setup then access phase; read the register back where it exists
  task automatic apb_write(input logic [2:0] idx, input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] rd;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    apply_reg(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx <= REG_SCALE) begin
      @(negedge clk);
      psel    <= 1'b1;
      paddr   <= {idx, 2'b00};
      @(negedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      rd = prdata;
      @(negedge clk);
      psel    <= 1'b0;
      penable <= 1'b0;
      if ((rd & reg_mask(idx)) !== (value & reg_mask(idx))) begin
        report_mismatch($sformatf("reg %0d reads %h, wrote %h", idx, rd, value));
      end
    end
  endtask

  function automatic logic [DATA_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return (DATA_W'(1) << GAIN_W) - 1;
      2, 3:    return $urandom_range(0, 1 << 17);
      default: return $urandom & ((DATA_W'(1) << GAIN_W) - 1);
    endcase
  endfunction

  // Release result requests, stalling in bursts while enabled
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (out_stall_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Check each accepted result against the oldest expectation
  always @(posedge clk) begin
    steer_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_steer_q.size() == 0) begin
        report_mismatch("result with nothing pending");
      end else begin
        want = pending_steer_q.pop_front();
        if (right_speed !== want.rs)
          report_mismatch($sformatf("right_speed %0d, want %0d", right_speed, want.rs));
        if (left_speed !== want.ls)
          report_mismatch($sformatf("left_speed %0d, want %0d", left_speed, want.ls));
        if (steer_correction !== want.corr)
          report_mismatch($sformatf("steer_correction %0d, want %0d",
                                    steer_correction, want.corr));
      end
    end
  end

  // Guard against a hung handshake
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    logic [DATA_W-1:0] cfg_vals [NUM_REGS];
    logic [SAMP_W-1:0] l, r;
    int                k, ph, n, mid;
    bit                quiet;

    rst          = 1'b1;
    in_valid     = 1'b0;
    left_sample  = '0;
    right_sample = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_gap_on    = 1'b0;
    out_stall_on = 1'b0;
    l            = '0;
    r            = '0;
    reset_steering();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // First pair after reset: default gains saturate at the cruise speed
    dir_tab.push_back(pair_known(10'd0, 10'd0, 8'd0, 8'd40, 9'sd40));
    dir_tab.push_back(pair_row(10'd1023, 10'd0));
    dir_tab.push_back(pair_row(10'd0, 10'd1023));
    dir_tab.push_back(pair_row(10'd1023, 10'd1023));
    dir_tab.push_back(pair_row(10'h2AA, 10'h155));
    dir_tab.push_back(pair_row(10'h155, 10'h2AA));
    // Zero cruise speed forces everything to zero
    dir_tab.push_back(cfg_row(REG_BASE, 32'd0));
    dir_tab.push_back(pair_known(10'd1023, 10'd0, 8'd0, 8'd0, 9'sd0));
    dir_tab.push_back(pair_known(10'd0, 10'd1023, 8'd0, 8'd0, 9'sd0));
    // Full proportional gain, clamp at both ends
    dir_tab.push_back(cfg_row(REG_BASE, 32'd255));
    dir_tab.push_back(cfg_row(REG_KP, 32'h00FF_FFFF));
    dir_tab.push_back(cfg_row(REG_KI, 32'd0));
    dir_tab.push_back(cfg_row(REG_KD, 32'd0));
    dir_tab.push_back(cfg_row(REG_OFFSET, 32'd0));
    dir_tab.push_back(cfg_row(REG_SCALE, 32'd4095));
    dir_tab.push_back(pair_known(10'd1023, 10'd0, 8'd0, 8'd255, 9'sd255));
    dir_tab.push_back(pair_known(10'd0, 10'd1023, 8'd255, 8'd0, -9'sd255));
    dir_tab.push_back(pair_known(10'd0, 10'd0, 8'd255, 8'd255, 9'sd0));
    // Position truncates toward zero with the most negative offset
    dir_tab.push_back(cfg_row(REG_KP, 32'd65536));
    dir_tab.push_back(cfg_row(REG_SCALE, 32'd1));
    dir_tab.push_back(cfg_row(REG_OFFSET, 32'hFFFF_FE00));
    dir_tab.push_back(pair_known(10'd0, 10'd1, 8'd255, 8'd253, -9'sd2));
    dir_tab.push_back(pair_known(10'd1, 10'd0, 8'd255, 8'd254, -9'sd1));
    dir_tab.push_back(pair_known(10'd1023, 10'd0, 8'd254, 8'd255, 9'sd1));
    // Correction truncates toward zero: -1.5 gives -1
    dir_tab.push_back(cfg_row(REG_KP, 32'd98304));
    dir_tab.push_back(pair_known(10'd1, 10'd0, 8'd255, 8'd254, -9'sd1));
    // Integral and derivative at full scale
    dir_tab.push_back(cfg_row(REG_KP, 32'd0));
    dir_tab.push_back(cfg_row(REG_KI, 32'h00FF_FFFF));
    dir_tab.push_back(cfg_row(REG_KD, 32'h00FF_FFFF));
    dir_tab.push_back(cfg_row(REG_BASE, 32'd128));
    dir_tab.push_back(cfg_row(REG_OFFSET, 32'd511));
    dir_tab.push_back(cfg_row(REG_SCALE, 32'd4095));
    dir_tab.push_back(pair_row(10'd1023, 10'd0));
    dir_tab.push_back(pair_row(10'd1023, 10'd0));
    dir_tab.push_back(pair_row(10'd1023, 10'd0));
    dir_tab.push_back(pair_row(10'd0, 10'd1023));
    dir_tab.push_back(pair_row(10'h2AA, 10'h155));
    dir_tab.push_back(pair_row(10'd1023, 10'd1023));
    dir_tab.push_back(pair_row(10'd512, 10'd512));
    // Writes past the register map are dropped
    dir_tab.push_back(cfg_row(IDX_SPARE_LO, 32'hFFFF_FFFF));
    dir_tab.push_back(cfg_row(IDX_SPARE_HI, 32'h5A5A_A5A5));
    dir_tab.push_back(pair_row(10'h155, 10'h2AA));

    // Walk the directed table; registers change only once drained
    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        if (i == 0 || !dir_tab[i-1].is_cfg) wait_drained();
        apb_write(dir_tab[i].idx, dir_tab[i].value);
      end else begin
        send_pair(dir_tab[i].l, dir_tab[i].r, dir_tab[i].known, dir_tab[i].want);
      end
    end

    // Randomized phases, each with its own settings
    for (ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      quiet = (ph == PHASES - 1);
      case (ph)
        0: begin
          cfg_vals[REG_KP]     = KP_RESET;
          cfg_vals[REG_KI]     = KI_RESET;
          cfg_vals[REG_KD]     = KD_RESET;
          cfg_vals[REG_BASE]   = BASE_RESET;
          cfg_vals[REG_OFFSET] = OFFSET_RESET;
          cfg_vals[REG_SCALE]  = SCALE_RESET;
        end
        1: begin
          cfg_vals[REG_KP]     = 32'h00FF_FFFF;
          cfg_vals[REG_KI]     = 32'h00FF_FFFF;
          cfg_vals[REG_KD]     = 32'h00FF_FFFF;
          cfg_vals[REG_BASE]   = 32'd255;
          cfg_vals[REG_OFFSET] = 32'd511;
          cfg_vals[REG_SCALE]  = 32'd4095;
        end
        2: begin
          cfg_vals[REG_KP]     = 32'd0;
          cfg_vals[REG_KI]     = 32'd0;
          cfg_vals[REG_KD]     = 32'd0;
          cfg_vals[REG_BASE]   = $urandom_range(0, 255);
          cfg_vals[REG_OFFSET] = 32'h200;
          cfg_vals[REG_SCALE]  = 32'd0;
        end
        default: begin
          cfg_vals[REG_KP]     = pick_gain();
          cfg_vals[REG_KI]     = pick_gain();
          cfg_vals[REG_KD]     = pick_gain();
          case ($urandom_range(0, 3))
            0:       cfg_vals[REG_BASE] = 32'd0;
            1:       cfg_vals[REG_BASE] = 32'd255;
            default: cfg_vals[REG_BASE] = $urandom_range(0, 255);
          endcase
          cfg_vals[REG_OFFSET] = $urandom_range(0, 1023);
          cfg_vals[REG_SCALE]  = $urandom_range(0, 1) ? $urandom_range(0, 4095)
                                                      : $urandom_range(128, 512);
        end
      endcase
      for (k = REG_KP; k <= REG_SCALE; k++) apb_write(3'(k), cfg_vals[k]);

      for (n = 0; n < PHASE_ITEMS; n++) begin
        // Toggle idling per stretch; none in the closing phase
        if (n % 50 == 0) begin
          in_gap_on    = quiet ? 1'b0 : 1'($urandom_range(0, 1));
          out_stall_on = quiet ? 1'b0 : 1'($urandom_range(0, 1));
        end
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            // Independent left and right samples; the right one is clamped to range
            mid = $urandom_range(0, 1023) + $urandom_range(0, 80) - 40;
            l   = SAMP_W'($urandom_range(0, 1023));
            r   = SAMP_W'((mid < 0) ? 0 : (mid > 1023) ? 1023 : mid);
          end
          4, 5: begin
            l = SAMP_W'($urandom_range(0, 1023));
            r = SAMP_W'($urandom_range(0, 1023));
          end
          6: begin
            l = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
            r = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
          end
          default: ;  // hold the previous pair to fill the window
        endcase
        send_pair(l, r, 1'b0, '0);
      end
    end

    // Drain, settle, then report
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (pending_steer_q.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_steer_q.size()));
    end
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
